>>> sv/apt_pkg.sv
// Shared types and fixed constants of the absolute pointer tracker.
// No dependencies; imported by every module of the block except apt_queue.
package apt_pkg;

  // Request kinds carried by req_type.
  typedef enum logic {
    REQ_REPORT = 1'b0,
    REQ_READ   = 1'b1
  } req_kind_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  // Reset screen size in pixels.
  localparam int unsigned RESET_WIDTH  = 1024;
  localparam int unsigned RESET_HEIGHT = 768;

  // Fixed field widths.
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned WHEEL_W = 8;

  // Button bits.
  localparam logic [BTN_W-1:0] BTN_LEFT   = 3'b001;
  localparam logic [BTN_W-1:0] BTN_RIGHT  = 3'b010;
  localparam logic [BTN_W-1:0] BTN_MIDDLE = 3'b100;
  localparam logic [BTN_W-1:0] BTN_MASK   = BTN_LEFT | BTN_RIGHT | BTN_MIDDLE;

endpackage

>>> sv/absolute_pointer_tracker.sv
// Top level of the absolute pointer tracker: front end, queue, back end.
// Depends on apt_pkg, apt_front, apt_queue and apt_back.
//
// Maps absolute tablet words onto a screen pointer. A report word (req_type
// 0) scales x and y to the screen size as (coord * size) >> COORD_BITS,
// clamps to size-1 and records the movement, held buttons, newly pressed
// buttons and wheel; its result word is the new state. A read word
// (req_type 1) returns the stored state and then clears deltas, clicks and
// scroll. Every input word gives exactly one result word, through the queue
// register and then the output register. One word per cycle is sustained
// while the output is not stalled: scale multiply and clamp sit in the front
// end, state update and output register in the back end, with a two-entry
// queue between so in_stall only rises once the queue is full behind a
// stalled output. Screen size registers are written via cfg_we/cfg_index/
// cfg_wdata; the user must do so only while the block is idle, which the
// block does not enforce. Size 0 acts as 1, sizes above 2^SCREEN_BITS as
// 2^SCREEN_BITS. After reset the pointer is centred on a 1024 x 768 screen.
module absolute_pointer_tracker import apt_pkg::*; #(
  parameter int unsigned COORD_BITS  = 15,
  parameter int unsigned SCREEN_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [SCREEN_BITS:0]         cfg_wdata,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [COORD_BITS-1:0]        in_abs_x,
  input  logic [COORD_BITS-1:0]        in_abs_y,
  input  logic [BTN_W-1:0]             in_button_bits,
  input  logic signed [WHEEL_W-1:0]    in_wheel,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SCREEN_BITS-1:0]       out_pos_x,
  output logic [SCREEN_BITS-1:0]       out_pos_y,
  output logic signed [SCREEN_BITS:0]  out_delta_x,
  output logic signed [SCREEN_BITS:0]  out_delta_y,
  output logic [BTN_W-1:0]             out_held_buttons,
  output logic [BTN_W-1:0]             out_click_flags,
  output logic signed [WHEEL_W-1:0]    out_scroll
);

  // kind, scaled x and y, buttons, wheel
  localparam int unsigned ENTRY_W = 1 + 2 * SCREEN_BITS + BTN_W + WHEEL_W;
  localparam int unsigned Q_DEPTH = 2;

  logic [ENTRY_W-1:0] fe_entry;
  logic [ENTRY_W-1:0] q_head;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;

  // front end: combinational scale/clamp feeding the queue register
  apt_front #(
    .COORD_BITS  (COORD_BITS),
    .SCREEN_BITS (SCREEN_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .req_type    (in_req_type),
    .abs_x       (in_abs_x),
    .abs_y       (in_abs_y),
    .button_bits (in_button_bits),
    .wheel       (in_wheel),
    .entry       (fe_entry)
  );

  // the queue full flag is registered, so in_stall never depends on in_valid
  assign in_stall = q_full;

  apt_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (fe_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  // back end: pointer state and output register
  apt_back #(
    .SCREEN_BITS (SCREEN_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_data           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_delta_x      (out_delta_x),
    .out_delta_y      (out_delta_y),
    .out_held_buttons (out_held_buttons),
    .out_click_flags  (out_click_flags),
    .out_scroll       (out_scroll)
  );

endmodule

>>> sv/apt_front.sv
// Front end: holds the screen size registers, classifies each incoming word
// and scales report coordinates to screen pixels. Depends on apt_pkg.
module apt_front import apt_pkg::*; #(
  parameter int unsigned COORD_BITS  = 15,
  parameter int unsigned SCREEN_BITS = 12,
  parameter int unsigned ENTRY_W     = 1 + 2 * SCREEN_BITS + BTN_W + WHEEL_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SCREEN_BITS:0]        cfg_wdata,
  input  logic                        req_type,
  input  logic [COORD_BITS-1:0]       abs_x,
  input  logic [COORD_BITS-1:0]       abs_y,
  input  logic [BTN_W-1:0]            button_bits,
  input  logic signed [WHEEL_W-1:0]   wheel,
  output logic [ENTRY_W-1:0]          entry
);

  localparam int unsigned SIZE_MAX = 1 << SCREEN_BITS;
  localparam int unsigned RST_W = (RESET_WIDTH  > SIZE_MAX) ? SIZE_MAX : RESET_WIDTH;
  localparam int unsigned RST_H = (RESET_HEIGHT > SIZE_MAX) ? SIZE_MAX : RESET_HEIGHT;
  localparam int unsigned PROD_W = COORD_BITS + SCREEN_BITS + 1;

  typedef struct packed {
    req_kind_t                 kind;
    logic [SCREEN_BITS-1:0]    nx;
    logic [SCREEN_BITS-1:0]    ny;
    logic [BTN_W-1:0]          btn;
    logic [WHEEL_W-1:0]        wheel;
  } entry_t;

  logic [SCREEN_BITS:0] width_r;
  logic [SCREEN_BITS:0] height_r;
  entry_t               ent;

  // (coord * size) >> COORD_BITS, clamped to size-1; size 0 acts as 1,
  // sizes past full scale act as full scale.
  function automatic logic [SCREEN_BITS-1:0] scale_axis(
    input logic [COORD_BITS-1:0]  coord,
    input logic [SCREEN_BITS:0]   reg_val
  );
    logic [SCREEN_BITS:0] size;
    logic [PROD_W-1:0]    prod;
    logic [SCREEN_BITS:0] v;
    if (reg_val == '0) begin
      size = (SCREEN_BITS+1)'(1);
    end else if (reg_val > (SCREEN_BITS+1)'(SIZE_MAX)) begin
      size = (SCREEN_BITS+1)'(SIZE_MAX);
    end else begin
      size = reg_val;
    end
    prod = PROD_W'(coord) * PROD_W'(size);
    v    = prod[PROD_W-1:COORD_BITS];
    if (v >= size) begin
      v = size - (SCREEN_BITS+1)'(1);
    end
    return v[SCREEN_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= (SCREEN_BITS+1)'(RST_W);
      height_r <= (SCREEN_BITS+1)'(RST_H);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    ent.kind  = req_kind_t'(req_type);
    ent.nx    = scale_axis(abs_x, width_r);
    ent.ny    = scale_axis(abs_y, height_r);
    ent.btn   = button_bits & BTN_MASK;
    ent.wheel = wheel;
  end

  assign entry = ENTRY_W'(ent);

endmodule

>>> sv/apt_queue.sv
// Short register FIFO between front and back end.
// Generic payload width; no package dependencies.
module apt_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/apt_back.sv
// Back end: pointer state, button edge detection and the output register.
// Depends on apt_pkg.
module apt_back import apt_pkg::*; #(
  parameter int unsigned SCREEN_BITS = 12,
  parameter int unsigned ENTRY_W     = 1 + 2 * SCREEN_BITS + BTN_W + WHEEL_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  logic [ENTRY_W-1:0]           q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SCREEN_BITS-1:0]       out_pos_x,
  output logic [SCREEN_BITS-1:0]       out_pos_y,
  output logic signed [SCREEN_BITS:0]  out_delta_x,
  output logic signed [SCREEN_BITS:0]  out_delta_y,
  output logic [BTN_W-1:0]             out_held_buttons,
  output logic [BTN_W-1:0]             out_click_flags,
  output logic signed [WHEEL_W-1:0]    out_scroll
);

  localparam int unsigned POS_MOD = 1 << SCREEN_BITS;
  localparam int unsigned RST_X   = (RESET_WIDTH / 2) % POS_MOD;
  localparam int unsigned RST_Y   = (RESET_HEIGHT / 2) % POS_MOD;

  typedef struct packed {
    req_kind_t                 kind;
    logic [SCREEN_BITS-1:0]    nx;
    logic [SCREEN_BITS-1:0]    ny;
    logic [BTN_W-1:0]          btn;
    logic [WHEEL_W-1:0]        wheel;
  } entry_t;

  entry_t                 ent;
  logic [SCREEN_BITS-1:0] cur_x_r, cur_y_r;
  logic [SCREEN_BITS:0]   dx_r, dy_r, dx_new, dy_new;
  logic [BTN_W-1:0]       held_r, clicks_r, clicks_new;
  logic [WHEEL_W-1:0]     scroll_r;
  logic                   out_valid_r;
  logic [SCREEN_BITS-1:0] o_x_r, o_y_r;
  logic [SCREEN_BITS:0]   o_dx_r, o_dy_r;
  logic [BTN_W-1:0]       o_held_r, o_clicks_r;
  logic [WHEEL_W-1:0]     o_scroll_r;

  assign ent   = entry_t'(q_data);
  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  // movement wraps to delta width
  assign dx_new     = {1'b0, ent.nx} - {1'b0, cur_x_r};
  assign dy_new     = {1'b0, ent.ny} - {1'b0, cur_y_r};
  assign clicks_new = ent.btn & ~held_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_x_r     <= SCREEN_BITS'(RST_X);
      cur_y_r     <= SCREEN_BITS'(RST_Y);
      dx_r        <= '0;
      dy_r        <= '0;
      held_r      <= '0;
      clicks_r    <= '0;
      scroll_r    <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        unique case (ent.kind)
          REQ_REPORT: begin
            cur_x_r  <= ent.nx;
            cur_y_r  <= ent.ny;
            dx_r     <= dx_new;
            dy_r     <= dy_new;
            held_r   <= ent.btn;
            clicks_r <= clicks_new;
            scroll_r <= ent.wheel;
          end
          REQ_READ: begin
            dx_r     <= '0;
            dy_r     <= '0;
            clicks_r <= '0;
            scroll_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // output word; a read shows the state before clearing
  always_ff @(posedge clk) begin
    if (q_pop) begin
      unique case (ent.kind)
        REQ_REPORT: begin
          o_x_r      <= ent.nx;
          o_y_r      <= ent.ny;
          o_dx_r     <= dx_new;
          o_dy_r     <= dy_new;
          o_held_r   <= ent.btn;
          o_clicks_r <= clicks_new;
          o_scroll_r <= ent.wheel;
        end
        REQ_READ: begin
          o_x_r      <= cur_x_r;
          o_y_r      <= cur_y_r;
          o_dx_r     <= dx_r;
          o_dy_r     <= dy_r;
          o_held_r   <= held_r;
          o_clicks_r <= clicks_r;
          o_scroll_r <= scroll_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = o_x_r;
  assign out_pos_y        = o_y_r;
  assign out_delta_x      = $signed(o_dx_r);
  assign out_delta_y      = $signed(o_dy_r);
  assign out_held_buttons = o_held_r;
  assign out_click_flags  = o_clicks_r;
  assign out_scroll       = $signed(o_scroll_r);

endmodule

>>> sim/absolute_pointer_tracker_test.sv
`timescale 1ns / 100ps
// Testbench for absolute_pointer_tracker: a queue-fed word driver, a stalling
// result monitor and an in-bench pointer tracker that predicts each result.
// Depends on apt_pkg and the absolute_pointer_tracker RTL.
module absolute_pointer_tracker_test;
  import apt_pkg::*;

  localparam int unsigned COORD_W  = 15;
  localparam int unsigned SCREEN_W = 12;
  localparam int unsigned REG_W    = SCREEN_W + 1;
  localparam int unsigned SIZE_CAP = 1 << SCREEN_W;
  localparam int unsigned COORD_FULL = (1 << COORD_W) - 1;
  localparam int unsigned QUIET_LIMIT = 4000;  // cycles with no handshake
  localparam int unsigned LONG_HOLD   = 300;   // receiver back-pressure burst
  localparam int unsigned SETTLE      = 4;     // cycles after drain

  // One tablet word as presented on the input channel.
  typedef struct {
    req_kind_t                   kind;
    logic [COORD_W-1:0]          ax;
    logic [COORD_W-1:0]          ay;
    logic [BTN_W-1:0]            btn;
    logic signed [WHEEL_W-1:0]   wheel;
  } tablet_word_t;

  // One pointer state word as seen on the result channel.
  typedef struct {
    logic [SCREEN_W-1:0]         px;
    logic [SCREEN_W-1:0]         py;
    logic signed [SCREEN_W:0]    dx;
    logic signed [SCREEN_W:0]    dy;
    logic [BTN_W-1:0]            held;
    logic [BTN_W-1:0]            clicks;
    logic signed [WHEEL_W-1:0]   scroll;
  } pointer_state_t;

  // Clock, reset, DUT ports. Every DUT input starts at a known value.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [REG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = REQ_REPORT;
  logic [COORD_W-1:0] in_abs_x = '0;
  logic [COORD_W-1:0] in_abs_y = '0;
  logic [BTN_W-1:0] in_button_bits = '0;
  logic signed [WHEEL_W-1:0] in_wheel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SCREEN_W-1:0] out_pos_x;
  logic [SCREEN_W-1:0] out_pos_y;
  logic signed [SCREEN_W:0] out_delta_x;
  logic signed [SCREEN_W:0] out_delta_y;
  logic [BTN_W-1:0] out_held_buttons;
  logic [BTN_W-1:0] out_click_flags;
  logic signed [WHEEL_W-1:0] out_scroll;

  absolute_pointer_tracker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_abs_x         (in_abs_x),
    .in_abs_y         (in_abs_y),
    .in_button_bits   (in_button_bits),
    .in_wheel         (in_wheel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_delta_x      (out_delta_x),
    .out_delta_y      (out_delta_y),
    .out_held_buttons (out_held_buttons),
    .out_click_flags  (out_click_flags),
    .out_scroll       (out_scroll)
  );

  // 20 ns period, high then low.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------
  // Pointer tracker shadow: screen size registers and pointer state, all
  // at their reset values. Pointer starts at the centre of 1024 x 768.
  // ---------------------------------------------------------------------
  logic [REG_W-1:0]        width_reg  = REG_W'(RESET_WIDTH);
  logic [REG_W-1:0]        height_reg = REG_W'(RESET_HEIGHT);
  logic [SCREEN_W-1:0]     ptr_x      = SCREEN_W'(RESET_WIDTH / 2);
  logic [SCREEN_W-1:0]     ptr_y      = SCREEN_W'(RESET_HEIGHT / 2);
  logic [SCREEN_W:0]       move_x     = '0;
  logic [SCREEN_W:0]       move_y     = '0;
  logic [BTN_W-1:0]        btn_held   = '0;
  logic [BTN_W-1:0]        btn_last   = '0;
  logic [BTN_W-1:0]        btn_click  = '0;
  logic [WHEEL_W-1:0]      wheel_last = '0;

  // Map one tablet coordinate onto a screen axis. A zero size acts as one
  // pixel, anything past 2^SCREEN_W as the full 2^SCREEN_W.
  function automatic logic [SCREEN_W-1:0] scale_to_screen(
      input logic [COORD_W-1:0] coord, input logic [REG_W-1:0] size_reg);
    int unsigned size;
    int unsigned v;
    size = (size_reg == 0) ? 1 : (size_reg > SIZE_CAP) ? SIZE_CAP : size_reg;
    v = (int'(coord) * size) >> COORD_W;
    if (v >= size) v = size - 1;
    return SCREEN_W'(v);
  endfunction

  // Apply one accepted word to the shadow state and return its result word.
  function automatic pointer_state_t track_word(input tablet_word_t w);
    pointer_state_t r;
    logic [SCREEN_W-1:0] nx;
    logic [SCREEN_W-1:0] ny;
    if (w.kind == REQ_REPORT) begin
      nx = scale_to_screen(w.ax, width_reg);
      ny = scale_to_screen(w.ay, height_reg);
      // wrap-around difference kept at delta width
      move_x = {1'b0, nx} - {1'b0, ptr_x};
      move_y = {1'b0, ny} - {1'b0, ptr_y};
      ptr_x = nx;
      ptr_y = ny;
      btn_held = w.btn;
      btn_click = w.btn & ~btn_last;
      btn_last = w.btn;
      wheel_last = w.wheel;
    end
    r.px = ptr_x;
    r.py = ptr_y;
    r.dx = move_x;
    r.dy = move_y;
    r.held = btn_held;
    r.clicks = btn_click;
    r.scroll = wheel_last;
    // a read reports first, then clears the one-shot fields
    if (w.kind == REQ_READ) begin
      move_x = '0;
      move_y = '0;
      btn_click = '0;
      wheel_last = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------
  tablet_word_t   tablet_words[$];  // words waiting for the driver
  pointer_state_t pointer_due[$];   // predicted result words, oldest first
  int unsigned    errors = 0;
  int unsigned    quiet_cycles = 0;
  bit             word_taken = 1'b0;   // set at the edge that accepts a word
  bit             long_hold_req = 1'b0;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents the next queued word at the falling edge, holds it
  // while stalled, then inserts a random gap. Calm stretches send
  // back-to-back.
  // ---------------------------------------------------------------------
  int unsigned send_gap = 0;
  int unsigned calm_tx = 0;

  always @(negedge clk) begin
    tablet_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      // stalled: word and valid stay put
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (tablet_words.size() != 0) begin
      w = tablet_words.pop_front();
      in_valid <= 1'b1;
      in_req_type <= w.kind;
      in_abs_x <= w.ax;
      in_abs_y <= w.ay;
      in_button_bits <= w.btn;
      in_wheel <= w.wheel;
      if (calm_tx > 0) begin
        calm_tx--;
        send_gap = 0;
      end else begin
        send_gap = idle_len();
        if ($urandom_range(0, 63) == 0) calm_tx = 40;
      end
    end else begin
      in_valid <= 1'b0;
    end
    word_taken = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Receiver stall pattern. A long hold request from the stimulus blocks
  // the output so the internal queue backs up into in_stall.
  // ---------------------------------------------------------------------
  int unsigned rx_hold = 0;
  int unsigned calm_rx = 0;

  always @(negedge clk) begin
    int unsigned n;
    if (long_hold_req) begin
      rx_hold = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (calm_rx > 0) begin
      calm_rx--;
      out_stall <= 1'b0;
    end else begin
      n = idle_len();
      if (n > 0) begin
        rx_hold = n - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) calm_rx = 40;
    end
  end

  // ---------------------------------------------------------------------
  // Rising edge: predict on accepted input words, check accepted result
  // words against the oldest prediction, and run the watchdog.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    tablet_word_t   w;
    pointer_state_t e;
    pointer_state_t got;
    bit             in_fire;
    bit             out_fire;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;

    if (in_fire) begin
      w.kind = req_kind_t'(in_req_type);
      w.ax = in_abs_x;
      w.ay = in_abs_y;
      w.btn = in_button_bits;
      w.wheel = in_wheel;
      pointer_due.push_back(track_word(w));
      word_taken = 1'b1;
    end

    if (out_fire) begin
      got.px = out_pos_x;
      got.py = out_pos_y;
      got.dx = out_delta_x;
      got.dy = out_delta_y;
      got.held = out_held_buttons;
      got.clicks = out_click_flags;
      got.scroll = out_scroll;
      if (pointer_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result word with nothing expected: pos %0d,%0d", $realtime,
                   got.px, got.py);
      end else begin
        e = pointer_due.pop_front();
        if (got.px !== e.px || got.py !== e.py || got.dx !== e.dx ||
            got.dy !== e.dy || got.held !== e.held ||
            got.clicks !== e.clicks || got.scroll !== e.scroll) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: mismatch exp pos %0d,%0d d %0d,%0d held %h click %h scroll %0d",
                     $realtime, e.px, e.py, e.dx, e.dy, e.held, e.clicks, e.scroll);
            $display("%0t:          got pos %0d,%0d d %0d,%0d held %h click %h scroll %0d",
                     $realtime, got.px, got.py, got.dx, got.dy, got.held, got.clicks,
                     got.scroll);
          end
        end
      end
    end

    // watchdog: too long without any handshake means the block hung
    if (in_fire || out_fire || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("absolute_pointer_tracker_test: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  logic [BTN_W-1:0] stim_btn = '0;

  task automatic queue_word(input req_kind_t kind, input int unsigned ax,
                            input int unsigned ay, input int unsigned btn,
                            input int wheel);
    tablet_word_t w;
    w.kind = kind;
    w.ax = COORD_W'(ax);
    w.ay = COORD_W'(ay);
    w.btn = BTN_W'(btn);
    w.wheel = WHEEL_W'(wheel);
    tablet_words.push_back(w);
  endtask

  // Random traffic: about a quarter reads (with junk in the ignored
  // fields), the rest reports. Buttons often repeat so that held-without-
  // click and release sequences show up, and coordinates hit the rails.
  task automatic queue_random(input int unsigned count);
    int unsigned ax;
    int unsigned ay;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: ax = 0;
        1: ax = COORD_FULL;
        default: ax = $urandom_range(0, COORD_FULL);
      endcase
      case ($urandom_range(0, 9))
        0: ay = 0;
        1: ay = COORD_FULL;
        default: ay = $urandom_range(0, COORD_FULL);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        queue_word(REQ_READ, ax, ay, $urandom_range(0, 7), $urandom_range(0, 255));
      end else begin
        if ($urandom_range(0, 9) >= 3) stim_btn = BTN_W'($urandom_range(0, 7));
        queue_word(REQ_REPORT, ax, ay, stim_btn, $urandom_range(0, 255));
      end
    end
  endtask

  // Block until every queued word is accepted and every result is back.
  task automatic wait_drained();
    do @(posedge clk);
    while (tablet_words.size() != 0 || in_valid || pointer_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write while idle; the shadow copy follows the same write.
  task automatic write_size(input logic [CFG_IDX_W-1:0] idx,
                            input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= REG_W'(value);
    if (idx == REG_SCREEN_WIDTH) width_reg = REG_W'(value);
    else height_reg = REG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  int unsigned widths[10];
  int unsigned heights[10];

  initial begin
    // screen settings per phase: a normal size, zero size (acts as one
    // pixel), oversized (clamped to 4096), exact max, just past max on one
    // axis with one pixel on the other (both ways round), then random ones
    widths  = '{640, 0, 8191, 4096, 4097, 1,    0, 0, 0, 0};
    heights = '{480, 0, 8191, 4096, 1,    4097, 0, 0, 0, 0};
    for (int i = 6; i < 10; i++) begin
      widths[i]  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 4096);
      heights[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 4096);
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset screen size.
    queue_word(REQ_READ,   0,          0,          0, 0);     // read straight after reset
    queue_word(REQ_REPORT, 0,          0,          0, 0);     // top-left corner
    queue_word(REQ_REPORT, COORD_FULL, COORD_FULL, 7, 127);   // bottom-right, all buttons
    queue_word(REQ_READ,   0,          0,          0, 0);     // read then clear
    queue_word(REQ_READ,   0,          0,          0, 0);     // repeated read: deltas, clicks and scroll cleared
    queue_word(REQ_REPORT, 16384,      16384,      0, -128);  // release everything
    queue_word(REQ_REPORT, 16384,      16384,      BTN_LEFT, 1);
    queue_word(REQ_REPORT, 16384,      16384,      BTN_LEFT | BTN_RIGHT, -1);
    queue_word(REQ_REPORT, 100,        32000,      BTN_RIGHT, 0);
    queue_word(REQ_REPORT, 32000,      100,        BTN_MIDDLE, 0);
    queue_word(REQ_REPORT, 32000,      100,        BTN_MIDDLE, 0);  // held, no new click
    queue_word(REQ_READ,   COORD_FULL, COORD_FULL, 7, 255);   // read ignores its fields
    queue_word(REQ_REPORT, 'h5555,     'h2AAA,     5, 'h55);
    queue_word(REQ_REPORT, 'h2AAA,     'h5555,     2, 'hAA);
    queue_word(REQ_REPORT, 1,          COORD_FULL - 1, 0, 0);
    queue_word(REQ_READ,   'h2AAA,     'h5555,     5, 'hAA);
    queue_random(150);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      // size change does not move the pointer; the first report of the
      // phase measures its delta from the old position
      write_size(REG_SCREEN_WIDTH, widths[p]);
      write_size(REG_SCREEN_HEIGHT, heights[p]);
      if (p == 2) long_hold_req = 1'b1;  // output blocked while input keeps coming
      if (p == 4) begin
        queue_random(85);
        wait_drained();                  // sender pauses until all results are in
        queue_random(85);
      end else begin
        queue_random(170);
      end
      wait_drained();
    end

    if (errors == 0)
      $display("absolute_pointer_tracker_test: done, clean");
    else
      $display("absolute_pointer_tracker_test: done, errors");
    $finish;
  end

endmodule

>>> files.f
sv/apt_pkg.sv
sv/apt_front.sv
sv/apt_queue.sv
sv/apt_back.sv
sv/absolute_pointer_tracker.sv
sim/absolute_pointer_tracker_test.sv
